[hdl/tlm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlm_pkg: shared types for the two-list merge block
// Word layouts of both channels, operation codes, controller states and the
// control group that the merge controller hands to each list store.
// ----------------------------------------------------------------------------
package tlm_pkg;

	localparam int unsigned KEY_W = 32;

	// Operation codes carried in the func field; code 3 is unused.
	typedef enum logic [1:0] {
		FUNC_LOAD_LEFT  = 2'd0,
		FUNC_LOAD_RIGHT = 2'd1,
		FUNC_START      = 2'd2
	} func_t;

	typedef struct packed {
		logic [1:0]              func;
		logic signed [KEY_W-1:0] value;
	} item_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] merged_value;
		logic                    last;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PRIME,
		ST_MERGE
	} state_t;

	// Per-store control from the merge controller.
	typedef struct packed {
		logic wr_en;
		logic rd_en;
		logic clear;
	} store_ctrl_t;

endpackage
`default_nettype wire

[hdl/tlm_stream_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlm_stream_if: valid/ready word channel
// One word moves at each rising edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface tlm_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

[hdl/tlm_list_store.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlm_list_store: one key list
// Append-only synchronous memory with a fill count and a registered read port.
// ----------------------------------------------------------------------------
module tlm_list_store #(
	parameter int unsigned LIST_DEPTH = 32,
	parameter int unsigned ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1,
	parameter int unsigned FILL_W     = $clog2(LIST_DEPTH + 1)
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire tlm_pkg::store_ctrl_t            ctrl,
	input  wire logic [ADDR_W-1:0]               raddr,
	input  wire logic signed [tlm_pkg::KEY_W-1:0] wdata,
	output logic signed [tlm_pkg::KEY_W-1:0]     rdata,
	output logic [FILL_W-1:0]                    fill
);
	import tlm_pkg::*;

	logic signed [KEY_W-1:0] mem_q [LIST_DEPTH];
	logic [FILL_W-1:0]       fill_q;
	logic signed [KEY_W-1:0] rdata_q;
	logic                    do_write;

	// A load into a full list is dropped.
	assign do_write = ctrl.wr_en && (fill_q < FILL_W'(LIST_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (ctrl.clear) begin
			fill_q <= '0;
		end else if (do_write) begin
			fill_q <= fill_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_write) begin
			mem_q[fill_q[ADDR_W-1:0]] <= wdata;
		end
		if (ctrl.rd_en) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
	assign fill  = fill_q;

endmodule
`default_nettype wire

[hdl/tlm_merge_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlm_merge_ctrl: load decoder and two-pointer merge sequencer
// Steers loads into the stores, walks both read pointers during a merge and
// holds the result word in an output register.
// ----------------------------------------------------------------------------
module tlm_merge_ctrl #(
	parameter int unsigned LIST_DEPTH = 32,
	parameter int unsigned ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1,
	parameter int unsigned FILL_W     = $clog2(LIST_DEPTH + 1),
	parameter int unsigned CNT_W      = $clog2(2 * LIST_DEPTH + 1)
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	tlm_stream_if.sink                            items,
	tlm_stream_if.source                          results,
	output tlm_pkg::store_ctrl_t                  left_ctrl,
	output tlm_pkg::store_ctrl_t                  right_ctrl,
	output logic [ADDR_W-1:0]                     left_raddr,
	output logic [ADDR_W-1:0]                     right_raddr,
	input  wire logic signed [tlm_pkg::KEY_W-1:0] left_head,
	input  wire logic signed [tlm_pkg::KEY_W-1:0] right_head,
	input  wire logic [FILL_W-1:0]                left_fill,
	input  wire logic [FILL_W-1:0]                right_fill
);
	import tlm_pkg::*;

	state_t state_q, state_d;

	logic [FILL_W-1:0] li_q, ri_q;
	logic [FILL_W-1:0] li_plus, ri_plus;
	logic [CNT_W-1:0]  remain_q;
	logic [CNT_W-1:0]  total;
	logic              out_valid_q;
	result_t           out_q;

	logic is_load_left, is_load_right, is_start;
	logic l_avail, r_avail, take_left, advance, last_pick;

	always_comb begin
		is_load_left  = 1'b0;
		is_load_right = 1'b0;
		is_start      = 1'b0;
		unique case (items.payload.func)
			FUNC_LOAD_LEFT:  is_load_left  = 1'b1;
			FUNC_LOAD_RIGHT: is_load_right = 1'b1;
			FUNC_START:      is_start      = 1'b1;
			default: ;
		endcase
	end

	assign total     = CNT_W'(left_fill) + CNT_W'(right_fill);
	assign li_plus   = li_q + 1'b1;
	assign ri_plus   = ri_q + 1'b1;
	assign l_avail   = li_q < left_fill;
	assign r_avail   = ri_q < right_fill;
	// Ties go to the right head: the left one wins only when strictly smaller.
	assign take_left = l_avail && (!r_avail || (left_head < right_head));
	assign advance   = (state_q == ST_MERGE) && (!out_valid_q || results.ready);
	assign last_pick = remain_q == CNT_W'(1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (items.valid && is_start && (total != '0)) begin
					state_d = ST_PRIME;
				end
			end
			ST_PRIME: state_d = ST_MERGE;
			ST_MERGE: begin
				if (advance && last_pick) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		left_ctrl   = '0;
		right_ctrl  = '0;
		left_raddr  = '0;
		right_raddr = '0;
		items.ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				items.ready      = 1'b1;
				left_ctrl.wr_en  = items.valid && is_load_left;
				right_ctrl.wr_en = items.valid && is_load_right;
				// Fetch both heads at entry zero as the merge starts.
				left_ctrl.rd_en  = items.valid && is_start && (total != '0);
				right_ctrl.rd_en = items.valid && is_start && (total != '0);
			end
			ST_PRIME: ;
			ST_MERGE: begin
				left_raddr       = li_plus[ADDR_W-1:0];
				right_raddr      = ri_plus[ADDR_W-1:0];
				left_ctrl.rd_en  = advance && take_left && (li_plus < left_fill);
				right_ctrl.rd_en = advance && !take_left && (ri_plus < right_fill);
				left_ctrl.clear  = advance && last_pick;
				right_ctrl.clear = advance && last_pick;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			li_q        <= '0;
			ri_q        <= '0;
			remain_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) begin
				li_q     <= '0;
				ri_q     <= '0;
				remain_q <= total;
			end else if (advance) begin
				remain_q <= remain_q - 1'b1;
				if (take_left) begin
					li_q <= li_plus;
				end else begin
					ri_q <= ri_plus;
				end
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.merged_value <= take_left ? left_head : right_head;
			out_q.last         <= last_pick;
		end
	end

	assign results.valid   = out_valid_q;
	assign results.payload = out_q;

endmodule
`default_nettype wire

[hdl/two_list_merge.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// two_list_merge: two-way merge of two ascending lists of signed keys
// Two list memories, a load decoder and a two-pointer merge sequencer.
// ----------------------------------------------------------------------------
// Each input word either appends its value to the left or right list or
// starts a merge. Loads are taken one per cycle while no merge runs; a load
// into a full list (LIST_DEPTH keys) is dropped silently. A start word reads
// the heads of both lists from their memories and then passes through a
// priming state, after which the first key enters the output register. From
// there it emits one key per cycle while the output side takes them, in
// ascending signed order from the two read pointers, left + right keys in
// all, with last high on the final key. On equal heads the right key goes
// first. When one list runs dry the other drains. Both lists are empty again
// after a merge, and a start with both lists empty gives no word. While a
// merge runs the input side is not ready; it is ready again once the final
// key sits in the output register, so the next loads overlap the hand-off
// of that key. Code 3 on func is accepted and ignored. There is no clearing
// pass after reset: of the list stores, only the fill counts reset.
// ----------------------------------------------------------------------------
module two_list_merge #(
	parameter int unsigned LIST_DEPTH = 32
) (
	input wire logic     clk,
	input wire logic     arst_n,
	tlm_stream_if.sink   items,
	tlm_stream_if.source results
);
	import tlm_pkg::*;

	// Address width of a list memory and width of a fill count.
	localparam int unsigned ADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int unsigned FILL_W = $clog2(LIST_DEPTH + 1);

	store_ctrl_t             left_ctrl, right_ctrl;
	logic [ADDR_W-1:0]       left_raddr, right_raddr;
	logic signed [KEY_W-1:0] left_head, right_head;
	logic [FILL_W-1:0]       left_fill, right_fill;

	// Both lists share the incoming value as write data; the controller
	// decides which one, if any, takes it.
	tlm_list_store #(
		.LIST_DEPTH (LIST_DEPTH),
		.ADDR_W     (ADDR_W),
		.FILL_W     (FILL_W)
	) u_left_store (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (left_ctrl),
		.raddr  (left_raddr),
		.wdata  (items.payload.value),
		.rdata  (left_head),
		.fill   (left_fill)
	);

	tlm_list_store #(
		.LIST_DEPTH (LIST_DEPTH),
		.ADDR_W     (ADDR_W),
		.FILL_W     (FILL_W)
	) u_right_store (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (right_ctrl),
		.raddr  (right_raddr),
		.wdata  (items.payload.value),
		.rdata  (right_head),
		.fill   (right_fill)
	);

	// The read data of each memory is the current head of its list; the
	// controller compares the two heads, emits the smaller and fetches the
	// next entry of the list it took from, so the new head is ready in the
	// following cycle.
	tlm_merge_ctrl #(
		.LIST_DEPTH (LIST_DEPTH),
		.ADDR_W     (ADDR_W),
		.FILL_W     (FILL_W)
	) u_merge_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.items       (items),
		.results     (results),
		.left_ctrl   (left_ctrl),
		.right_ctrl  (right_ctrl),
		.left_raddr  (left_raddr),
		.right_raddr (right_raddr),
		.left_head   (left_head),
		.right_head  (right_head),
		.left_fill   (left_fill),
		.right_fill  (right_fill)
	);

endmodule
`default_nettype wire

[verif/two_list_merge_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_list_merge_tb: self-checking bench for the two-list merge block
// Loads sorted and unsorted key lists, starts merges and checks every merged
// word against a model kept in a small scoreboard. It runs under several
// idle and stall mixes and includes a long output hold-off.
// ----------------------------------------------------------------------------
module two_list_merge_tb;
	import tlm_pkg::*;

	localparam int unsigned LIST_DEPTH     = 32;
	localparam logic [1:0]  FUNC_UNUSED    = 2'd3;
	localparam int          HOLDOFF_CYCLES = 250;
	localparam int          TAIL_CYCLES    = 16;
	localparam int          PHASE_WORDS    = 60;
	localparam int          KEY_MIN        = 32'sh8000_0000;
	localparam int          KEY_MAX        = 32'sh7fff_ffff;

	// Scoreboard: mirrors both list stores and queues the merged words that
	// each start word must produce.
	class merge_scoreboard;
		int unsigned depth;
		int          left_keys[$];
		int          right_keys[$];
		result_t     expected_keys[$];
		int          error_count;

		function new(int unsigned list_depth);
			depth       = list_depth;
			error_count = 0;
		endfunction

		// Two-pointer merge of the mirrored stores. The left head only wins
		// when it is strictly smaller, so ties emit the right key first.
		function void predict_merge();
			int      li;
			int      ri;
			int      total;
			bit      take_left;
			result_t r;
			li    = 0;
			ri    = 0;
			total = left_keys.size() + right_keys.size();
			for (int k = 0; k < total; k++) begin
				if (li < left_keys.size() && ri < right_keys.size()) begin
					take_left = left_keys[li] < right_keys[ri];
				end else begin
					take_left = li < left_keys.size();
				end
				if (take_left) begin
					r.merged_value = left_keys[li];
					li++;
				end else begin
					r.merged_value = right_keys[ri];
					ri++;
				end
				r.last = (k == total - 1);
				expected_keys.push_back(r);
			end
			left_keys.delete();
			right_keys.delete();
		endfunction

		function void note_word(item_t w);
			case (w.func)
				FUNC_LOAD_LEFT: begin
					if (left_keys.size() < depth) left_keys.push_back(w.value);
				end
				FUNC_LOAD_RIGHT: begin
					if (right_keys.size() < depth) right_keys.push_back(w.value);
				end
				FUNC_START: begin
					predict_merge();
				end
				default: begin
				end
			endcase
		endfunction

		function void check_word(result_t got);
			result_t want;
			if (expected_keys.size() == 0) begin
				$error("unexpected merged word: merged_value %0d, last %0b",
					got.merged_value, got.last);
				error_count++;
				return;
			end
			want = expected_keys.pop_front();
			if (got.merged_value !== want.merged_value) begin
				$error("merged_value mismatch: expected %0d, actual %0d",
					want.merged_value, got.merged_value);
				error_count++;
			end
			if (got.last !== want.last) begin
				$error("last mismatch: expected %0b, actual %0b", want.last, got.last);
				error_count++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	tlm_stream_if #(.payload_t(item_t))   items_if ();
	tlm_stream_if #(.payload_t(result_t)) results_if ();

	two_list_merge #(
		.LIST_DEPTH(LIST_DEPTH)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items_if.sink),
		.results(results_if.source)
	);

	merge_scoreboard sb = new(LIST_DEPTH);

	// Idle mix, set per phase by the stimulus process.
	int sender_idle_pct = 0;
	int recv_stall_pct  = 0;
	// Count of input words that do something (unused codes are left out).
	int words_sent      = 0;
	// Raised by the stimulus to ask the output side for a long hold-off.
	bit holdoff_req     = 1'b0;

	always #2 clk = ~clk;

	// Output side. Words are checked on the edge where they are taken; the
	// ready decision for the next cycle is made in the same step. A hold-off
	// request is counted down here, independent of the sender.
	initial begin
		int holdoff_left;
		holdoff_left = 0;
		results_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (results_if.valid === 1'b1 && results_if.ready === 1'b1) begin
				sb.check_word(results_if.payload);
			end
			if (holdoff_req) begin
				holdoff_left = HOLDOFF_CYCLES;
				holdoff_req  = 1'b0;
			end
			if (holdoff_left > 0) begin
				holdoff_left--;
				results_if.ready <= 1'b0;
			end else begin
				results_if.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Offers one word, after a random number of idle cycles, and returns on
	// the edge where it was taken. The caller offers its next word in that
	// same step, so valid drops between words only when the sender idles.
	task automatic send_word(item_t w);
		while ($urandom_range(99) < sender_idle_pct) begin
			items_if.valid <= 1'b0;
			@(posedge clk);
		end
		items_if.valid   <= 1'b1;
		items_if.payload <= w;
		do @(posedge clk); while (items_if.ready !== 1'b1);
		sb.note_word(w);
		if (w.func != FUNC_UNUSED) words_sent++;
	endtask

	task automatic send_op(logic [1:0] f, int v);
		item_t w;
		w.func  = f;
		w.value = v;
		send_word(w);
	endtask

	// Holds the input quiet until every queued merged word has come out,
	// then lets the tail of the block's pipeline settle.
	task automatic wait_for_drain();
		items_if.valid <= 1'b0;
		while (sb.expected_keys.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// Narrow keys fall in a tiny range so that heads tie often; wide keys
	// are full 32-bit patterns with the extremes mixed in.
	function automatic int pick_key(bit narrow);
		if (narrow) return int'($urandom_range(8)) - 4;
		case ($urandom_range(19))
			0:       return KEY_MIN;
			1:       return KEY_MAX;
			2:       return 0;
			3:       return -1;
			default: return int'($urandom());
		endcase
	endfunction

	// Mostly short lists; now and then a full one, or one that overflows.
	function automatic int pick_size();
		if ($urandom_range(99) < 8) return LIST_DEPTH + $urandom_range(2);
		return $urandom_range(6);
	endfunction

	// A well-formed job: two ascending lists whose loads are interleaved at
	// random, followed by a start word. With hold_results set, the output
	// side is told to hold off just before the start goes in.
	task automatic run_merge_job(int n_left, int n_right, bit narrow, bit hold_results);
		int lk[$];
		int rk[$];
		repeat (n_left) lk.push_back(pick_key(narrow));
		repeat (n_right) rk.push_back(pick_key(narrow));
		lk.sort();
		rk.sort();
		while (lk.size() > 0 || rk.size() > 0) begin
			if (rk.size() == 0 || (lk.size() > 0 && $urandom_range(1) == 1)) begin
				send_op(FUNC_LOAD_LEFT, lk.pop_front());
			end else begin
				send_op(FUNC_LOAD_RIGHT, rk.pop_front());
			end
		end
		if (hold_results) holdoff_req = 1'b1;
		send_op(FUNC_START, int'($urandom()));
	endtask

	// Stimulus.
	initial begin
		int sender_pcts[4];
		int recv_pcts[4];
		int target;
		int pick;
		sender_pcts = '{0, 79, 0, 21};
		recv_pcts   = '{0, 0, 79, 21};

		arst_n           <= 1'b0;
		items_if.valid   <= 1'b0;
		items_if.payload <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. A start with nothing loaded yields no word, and an
		// unused code must leave both lists alone.
		send_op(FUNC_START, -1);
		send_op(FUNC_UNUSED, -1);
		// Extremes on both sides with two ties: the right key goes first on
		// each of them.
		send_op(FUNC_LOAD_LEFT, KEY_MIN);
		send_op(FUNC_LOAD_LEFT, -1);
		send_op(FUNC_LOAD_LEFT, 0);
		send_op(FUNC_LOAD_RIGHT, KEY_MIN);
		send_op(FUNC_LOAD_RIGHT, 0);
		send_op(FUNC_LOAD_RIGHT, KEY_MAX);
		send_op(FUNC_START, 0);
		// Only the left list holds keys, then only the right one.
		send_op(FUNC_LOAD_LEFT, 5);
		send_op(FUNC_LOAD_LEFT, 7);
		send_op(FUNC_START, KEY_MAX);
		send_op(FUNC_LOAD_RIGHT, KEY_MAX);
		send_op(FUNC_START, KEY_MIN);
		// Keys loaded out of order still go through the same merge.
		send_op(FUNC_LOAD_LEFT, 10);
		send_op(FUNC_LOAD_LEFT, 3);
		send_op(FUNC_LOAD_RIGHT, 5);
		send_op(FUNC_START, 0);
		// An unused code between a load and a start changes nothing.
		send_op(FUNC_LOAD_LEFT, 1);
		send_op(FUNC_UNUSED, 2);
		send_op(FUNC_START, 1);
		wait_for_drain();

		// Pressure: both lists overflow, the output side holds off during
		// the merge and the next job keeps pushing against a stalled input.
		run_merge_job(LIST_DEPTH + 1, LIST_DEPTH + 2, 1'b0, 1'b1);
		run_merge_job(3, 4, 1'b1, 1'b0);
		wait_for_drain();

		// Random part, one phase per idle mix.
		for (int ph = 0; ph < 4; ph++) begin
			sender_idle_pct = sender_pcts[ph];
			recv_stall_pct  = recv_pcts[ph];
			target          = words_sent + PHASE_WORDS;
			while (words_sent < target) begin
				pick = $urandom_range(99);
				if (pick < 75) begin
					run_merge_job(pick_size(), pick_size(), $urandom_range(99) < 30, 1'b0);
				end else if (pick < 85) begin
					// Broken sequence: keys in no particular order.
					repeat ($urandom_range(1, 5)) begin
						send_op(2'($urandom_range(1)), int'($urandom()));
					end
					send_op(FUNC_START, int'($urandom()));
				end else if (pick < 93) begin
					send_op(FUNC_UNUSED, int'($urandom()));
				end else begin
					send_op(FUNC_START, int'($urandom()));
				end
			end
			wait_for_drain();
		end

		if (sb.expected_keys.size() != 0) begin
			$error("%0d expected merged words never arrived", sb.expected_keys.size());
			sb.error_count++;
		end
		if (sb.error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin
		#1_600_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
